// ===== rtl/rrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared constants, codes and controller/datapath types of the received
// range coalescer.
// ----------------------------------------------------------------------------
package rrc_pkg;

   localparam int MAX_RANGES = 16;
   localparam int IDX_W      = $clog2(MAX_RANGES);
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);

   localparam int OFS_W  = 48;
   localparam int LEN_W  = 32;
   localparam int END_W  = 49;
   localparam int HELD_W = 5;
   localparam int STAT_W = 2;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REPORT = 1'b1
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_STORED = 2'd0,
      ST_FULL   = 2'd1,
      ST_REPORT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      WALK_SCAN,
      WALK_MOVE,
      WALK_REPORT
   } walk_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_DECIDE,
      S_MOVE,
      S_COMMIT,
      S_RESULT,
      S_RPT_RD,
      S_RPT_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       walk_scan;
      logic       walk_move;
      logic       walk_report;
      logic       walk_step;
      logic       commit;
      logic       set_status;
      status_type status;
      logic       rsp_load;
      logic       rsp_entry;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    len_zero;
      logic    list_empty;
      logic    full_no_hit;
      logic    walk_busy;
      logic    walk_left_zero;
      logic    out_free;
   } stat_type;

endpackage

// ===== rtl/rrc_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_chan_if
// Valid/ready channels of the received range coalescer: the request
// channel and the response channel.
// ----------------------------------------------------------------------------
interface rrc_req_if import rrc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [OFS_W-1:0] range_offset;
   logic [LEN_W-1:0] range_length;

   modport source (output valid, cmd, range_offset, range_length, input ready);
   modport sink (input valid, cmd, range_offset, range_length, output ready);
endinterface

interface rrc_rsp_if import rrc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OFS_W-1:0]  range_start;
   logic [END_W-1:0]  range_end;
   logic              has_range;
   logic              last;
   logic [STAT_W-1:0] status;
   logic [HELD_W-1:0] entries_held;

   modport source (output valid, range_start, range_end, has_range, last, status,
                   entries_held, input ready);
   modport sink (input valid, range_start, range_end, has_range, last, status,
                 entries_held, output ready);
endinterface

// ===== rtl/rrc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_ctrl
// Controller of the received range coalescer: sequences dispatch, scan,
// compaction, commit and response for an insert, and the table read-out for a report.
// ----------------------------------------------------------------------------
module rrc_ctrl import rrc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctl_type  ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      ctl.status = ST_STORED;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ctl.set_status = 1'b1;
            if (stat.cmd == CMD_REPORT) begin
               ctl.status = ST_REPORT;
               if (stat.list_empty) begin
                  state_in = S_RESULT;
               end else begin
                  ctl.walk_report = 1'b1;
                  state_in        = S_RPT_RD;
               end
            end else if (stat.len_zero) begin
               ctl.status = ST_STORED;
               state_in   = S_RESULT;
            end else begin
               ctl.walk_scan = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.walk_busy) begin
               ctl.walk_step = 1'b1;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            ctl.set_status = 1'b1;
            if (stat.full_no_hit) begin
               ctl.status = ST_FULL;
               state_in   = S_RESULT;
            end else begin
               ctl.status    = ST_STORED;
               ctl.walk_move = 1'b1;
               state_in      = S_MOVE;
            end
         end
         S_MOVE: begin
            if (stat.walk_busy) begin
               ctl.walk_step = 1'b1;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            ctl.commit = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RPT_RD: begin
            ctl.walk_step = 1'b1;
            state_in      = S_RPT_OUT;
         end
         S_RPT_OUT: begin
            if (stat.out_free) begin
               ctl.rsp_load  = 1'b1;
               ctl.rsp_entry = 1'b1;
               state_in      = stat.walk_left_zero ? S_IDLE : S_RPT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/rrc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_datapath
// Datapath of the received range coalescer: range table, table walker,
// overlap scan, merged range, entry count and response register.
// ----------------------------------------------------------------------------
module rrc_datapath import rrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ctl_type          ctl,
   output stat_type         stat,
   input  logic             req_cmd,
   input  logic [OFS_W-1:0] req_range_offset,
   input  logic [LEN_W-1:0] req_range_length,
   rrc_rsp_if.source        rsp
);

   logic [OFS_W-1:0] start_mem [MAX_RANGES];
   logic [END_W-1:0] end_mem [MAX_RANGES];

   cmd_type          cmd_ff;
   logic             len_zero_ff;
   logic [OFS_W-1:0] s_ff;
   logic [END_W-1:0] e_ff;

   logic [OFS_W-1:0] ms_ff;
   logic [END_W-1:0] me_ff;
   logic [CNT_W-1:0] below_ff;
   logic [CNT_W-1:0] hits_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   status_type       status_ff;

   walk_type         mode_ff;
   logic             up_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] left_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic [OFS_W-1:0] rd_start_ff;
   logic [END_W-1:0] rd_end_ff;

   logic             issue;
   logic             below;
   logic             above;
   logic             hit;
   logic             mv_we;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [OFS_W-1:0] mem_wstart;
   logic [END_W-1:0] mem_wend;
   logic [CNT_W-1:0] move_left;

   logic              rsp_valid_ff;
   logic [OFS_W-1:0]  rsp_start_ff;
   logic [END_W-1:0]  rsp_end_ff;
   logic              rsp_has_ff;
   logic              rsp_last_ff;
   status_type        rsp_status_ff;
   logic [HELD_W-1:0] rsp_held_ff;
   logic              out_free;

   // request capture
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff      <= cmd_type'(req_cmd);
         len_zero_ff <= (req_range_length == '0);
         s_ff        <= req_range_offset;
         e_ff        <= END_W'(req_range_offset) + END_W'(req_range_length);
      end
   end

   // overlap scan
   assign below = (rd_end_ff < END_W'(s_ff));
   assign above = (END_W'(rd_start_ff) > e_ff);
   assign hit   = !below && !above;

   always_ff @(posedge clock) begin
      if (ctl.walk_scan) begin
         ms_ff    <= s_ff;
         me_ff    <= e_ff;
         below_ff <= '0;
         hits_ff  <= '0;
      end else if (mode_ff == WALK_SCAN && rd_vld_ff) begin
         if (below) begin
            below_ff <= below_ff + CNT_W'(1);
         end
         if (hit) begin
            hits_ff <= hits_ff + CNT_W'(1);
            if (rd_start_ff < ms_ff) begin
               ms_ff <= rd_start_ff;
            end
            if (rd_end_ff > me_ff) begin
               me_ff <= rd_end_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.set_status) begin
         status_ff <= ctl.status;
      end
   end

   // table walker
   assign issue     = ctl.walk_step && (left_ff != '0);
   assign move_left = count_ff - below_ff - hits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         rd_vld_ff <= 1'b0;
         mode_ff   <= WALK_SCAN;
      end else begin
         rd_vld_ff <= issue;
         if (ctl.walk_scan) begin
            mode_ff <= WALK_SCAN;
            left_ff <= count_ff;
         end else if (ctl.walk_move) begin
            mode_ff <= WALK_MOVE;
            left_ff <= move_left;
         end else if (ctl.walk_report) begin
            mode_ff <= WALK_REPORT;
            left_ff <= count_ff;
         end else if (issue) begin
            left_ff <= left_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.walk_scan || ctl.walk_report) begin
         idx_ff <= '0;
         up_ff  <= 1'b1;
      end else if (ctl.walk_move) begin
         if (hits_ff == '0) begin
            idx_ff <= IDX_W'(count_ff - CNT_W'(1));
            up_ff  <= 1'b0;
         end else begin
            idx_ff <= IDX_W'(below_ff + hits_ff);
            up_ff  <= 1'b1;
         end
      end else if (issue) begin
         idx_ff <= up_ff ? idx_ff + IDX_W'(1) : idx_ff - IDX_W'(1);
      end
   end

   // table write port
   assign mv_we  = (mode_ff == WALK_MOVE) && rd_vld_ff;
   assign mem_we = mv_we || ctl.commit;

   always_comb begin
      if (ctl.commit) begin
         mem_waddr  = IDX_W'(below_ff);
         mem_wstart = ms_ff;
         mem_wend   = me_ff;
      end else begin
         mem_waddr  = (hits_ff == '0) ? rd_addr_ff + IDX_W'(1)
                                      : rd_addr_ff - IDX_W'(hits_ff - CNT_W'(1));
         mem_wstart = rd_start_ff;
         mem_wend   = rd_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[mem_waddr] <= mem_wstart;
         end_mem[mem_waddr]   <= mem_wend;
      end
      if (issue) begin
         rd_start_ff <= start_mem[idx_ff];
         rd_end_ff   <= end_mem[idx_ff];
         rd_addr_ff  <= idx_ff;
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (ctl.commit) begin
         count_in = count_ff + CNT_W'(1) - hits_ff;
      end else if (ctl.walk_report) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response register
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.rsp_load || (rsp_valid_ff && !rsp.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_start_ff  <= ctl.rsp_entry ? rd_start_ff : '0;
         rsp_end_ff    <= ctl.rsp_entry ? rd_end_ff : '0;
         rsp_has_ff    <= ctl.rsp_entry;
         rsp_last_ff   <= ctl.rsp_entry ? (left_ff == '0) : 1'b1;
         rsp_status_ff <= status_ff;
         rsp_held_ff   <= HELD_W'(count_ff);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.range_start  = rsp_start_ff;
   assign rsp.range_end    = rsp_end_ff;
   assign rsp.has_range    = rsp_has_ff;
   assign rsp.last         = rsp_last_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.entries_held = rsp_held_ff;

   // status to controller
   assign stat.cmd            = cmd_ff;
   assign stat.len_zero       = len_zero_ff;
   assign stat.list_empty     = (count_ff == '0);
   assign stat.full_no_hit    = (hits_ff == '0) && (count_ff == CNT_W'(MAX_RANGES));
   assign stat.walk_busy      = (left_ff != '0) || rd_vld_ff;
   assign stat.walk_left_zero = (left_ff == '0);
   assign stat.out_free       = out_free;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RANGES))
      else $error("entry count beyond table depth");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("response loaded over a pending transaction");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (hits_ff != '0) || (count_ff != CNT_W'(MAX_RANGES)))
      else $error("commit into a full table without merge");

   a_write_port: assert property (@(posedge clock) disable iff (reset)
      mv_we |-> !ctl.commit)
      else $error("table write port contention");

endmodule

// ===== rtl/received_range_coalescer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// received_range_coalescer
// Sorted list of disjoint received byte ranges with insert-and-merge and
// report-and-clear requests.
// ----------------------------------------------------------------------------
// One request transaction at a time. An insert on a table of stored ranges
// goes through these steps, from acceptance to the next acceptance:
// - dispatch;
// - one pass over the table to find the overlapping and touching ranges;
// - a decision step;
// - a second pass that shifts the ranges above the merged one;
// - commit, result and the return to idle.
// Both passes go through the single read port of the range table, one entry
// per cycle. An insert dropped on a full table skips the second pass and the
// commit, and a zero-length insert goes from dispatch straight to the result.
// A report reads each stored range in turn through the table read port and
// sends it as its own response, waiting for the output register each time.
// Either request waits longer while the previous response still sits in the
// output register. The next request is taken while the previous response
// waits in the output register. The table needs no clearing pass after reset.
module received_range_coalescer import rrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rrc_req_if.sink    req_if,
   rrc_rsp_if.source  rsp_if
);

   ctl_type  ctl;
   stat_type stat;
   logic     req_ready;

   assign req_if.ready = req_ready;

   rrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   rrc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_cmd          (req_if.cmd),
      .req_range_offset (req_if.range_offset),
      .req_range_length (req_if.range_length),
      .rsp              (rsp_if)
   );

endmodule

// ===== tb/sv/received_range_coalescer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// received_range_coalescer_test
// Self-checking bench for the received range coalescer. A driver feeds insert
// and report transactions from a queue. A monitor predicts the sorted, merged
// range list and checks every response field in order. Both channels idle in
// random bursts.
// ----------------------------------------------------------------------------
module received_range_coalescer_test;
   import rrc_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DRAIN_CYCLES  = 2 * MAX_RANGES + 16;
   localparam int RANDOM_ITEMS  = 430;
   localparam int CALM_ITEMS    = 60;

   typedef struct {
      cmd_type          cmd;
      logic [OFS_W-1:0] ofs;
      logic [LEN_W-1:0] len;
      int               gap;
   } range_request_type;

   typedef struct packed {
      logic [OFS_W-1:0]  range_start;
      logic [END_W-1:0]  range_end;
      logic              has_range;
      logic              last;
      status_type        status;
      logic [HELD_W-1:0] entries_held;
   } range_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrc_req_if req_if ();
   rrc_rsp_if rsp_if ();

   received_range_coalescer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   range_request_type pending[$];
   range_result_type  due_results[$];

   logic [OFS_W-1:0] held_start [MAX_RANGES];
   logic [END_W-1:0] held_end [MAX_RANGES];
   int               held_count = 0;

   int                errors = 0;
   int                cycle_count = 0;
   int                rsp_count = 0;
   int                req_gap = 0;
   int                rsp_stall = 0;
   int                rsp_quiet = 0;
   logic              req_taken = 1'b0;
   range_result_type  want_rsp;
   range_request_type next_req;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("[%0t] result %0d: %s got %h expected %h", $realtime, rsp_count, what, got,
               want);
   endtask

   function automatic status_type coalesce_insert(logic [OFS_W-1:0] ofs,
                                                  logic [LEN_W-1:0] len);
      logic [END_W-1:0] lo;
      logic [END_W-1:0] hi;
      logic [OFS_W-1:0] new_start [MAX_RANGES];
      logic [END_W-1:0] new_end [MAX_RANGES];
      int               touching;
      int               kept;
      bit               placed;
      int               i;
      lo = {1'b0, ofs};
      hi = lo + {{(END_W - LEN_W){1'b0}}, len};
      if (len == '0)
         return ST_STORED;
      touching = 0;
      for (i = 0; i < held_count; i++)
         if (!(held_end[i] < lo || {1'b0, held_start[i]} > hi))
            touching++;
      if (touching == 0 && held_count >= MAX_RANGES)
         return ST_FULL;
      kept = 0;
      placed = 1'b0;
      for (i = 0; i < held_count; i++) begin
         if (held_end[i] < lo) begin
            new_start[kept] = held_start[i];
            new_end[kept] = held_end[i];
            kept++;
         end else if ({1'b0, held_start[i]} > hi) begin
            if (!placed && kept < MAX_RANGES) begin
               new_start[kept] = lo[OFS_W-1:0];
               new_end[kept] = hi;
               kept++;
               placed = 1'b1;
            end
            if (kept < MAX_RANGES) begin
               new_start[kept] = held_start[i];
               new_end[kept] = held_end[i];
               kept++;
            end
         end else begin
            if ({1'b0, held_start[i]} < lo)
               lo = {1'b0, held_start[i]};
            if (held_end[i] > hi)
               hi = held_end[i];
         end
      end
      if (!placed && kept < MAX_RANGES) begin
         new_start[kept] = lo[OFS_W-1:0];
         new_end[kept] = hi;
         kept++;
      end
      for (i = 0; i < kept; i++) begin
         held_start[i] = new_start[i];
         held_end[i] = new_end[i];
      end
      held_count = kept;
      return ST_STORED;
   endfunction

   function automatic void predict_request(cmd_type cmd, logic [OFS_W-1:0] ofs,
                                           logic [LEN_W-1:0] len);
      range_result_type r;
      int               i;
      r = '0;
      r.last = 1'b1;
      if (cmd == CMD_INSERT) begin
         r.status = coalesce_insert(ofs, len);
         r.entries_held = HELD_W'(held_count);
         due_results.push_back(r);
      end else begin
         r.status = ST_REPORT;
         if (held_count == 0)
            due_results.push_back(r);
         for (i = 0; i < held_count; i++) begin
            r.range_start = held_start[i];
            r.range_end = held_end[i];
            r.has_range = 1'b1;
            r.last = (i == held_count - 1);
            due_results.push_back(r);
         end
         held_count = 0;
      end
   endfunction

   // accept, predict, compare
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready)
            predict_request(cmd_type'(req_if.cmd), req_if.range_offset, req_if.range_length);
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("unexpected transaction, status", rsp_if.status, 0);
            end else begin
               want_rsp = due_results.pop_front();
               if (rsp_if.range_start !== want_rsp.range_start)
                  report_mismatch("range_start", rsp_if.range_start, want_rsp.range_start);
               if (rsp_if.range_end !== want_rsp.range_end)
                  report_mismatch("range_end", rsp_if.range_end, want_rsp.range_end);
               if (rsp_if.has_range !== want_rsp.has_range)
                  report_mismatch("has_range", rsp_if.has_range, want_rsp.has_range);
               if (rsp_if.last !== want_rsp.last)
                  report_mismatch("last", rsp_if.last, want_rsp.last);
               if (rsp_if.status !== want_rsp.status)
                  report_mismatch("status", rsp_if.status, want_rsp.status);
               if (rsp_if.entries_held !== want_rsp.entries_held)
                  report_mismatch("entries_held", rsp_if.entries_held,
                                  want_rsp.entries_held);
            end
            rsp_count++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (pending.size() > 0 && pending[0].gap > 0) begin
            req_gap = pending[0].gap - 1;
            pending[0].gap = 0;
            req_if.valid <= 1'b0;
         end else if (pending.size() > 0) begin
            next_req = pending.pop_front();
            req_if.cmd <= next_req.cmd;
            req_if.range_offset <= next_req.ofs;
            req_if.range_length <= next_req.len;
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else if (pending.size() < CALM_ITEMS || rsp_quiet > 0) begin
         if (rsp_quiet > 0)
            rsp_quiet--;
         rsp_if.ready <= 1'b1;
      end else if ($urandom_range(0, 63) == 0) begin
         rsp_quiet = $urandom_range(50, 300);
         rsp_if.ready <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(1, 19) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic add_insert(logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] len, int gap);
      range_request_type r;
      r.cmd = CMD_INSERT;
      r.ofs = ofs;
      r.len = len;
      r.gap = gap;
      pending.push_back(r);
   endtask

   task automatic add_report(int gap);
      range_request_type r;
      r.cmd = CMD_REPORT;
      r.ofs = '0;
      r.len = '0;
      r.gap = gap;
      pending.push_back(r);
   endtask

   function automatic int pick_gap(bit gapped);
      if (gapped && $urandom_range(0, 3) == 0)
         return $urandom_range(1, 19);
      return 0;
   endfunction

   initial begin
      logic [63:0]      wide;
      logic [OFS_W-1:0] base;
      logic [LEN_W-1:0] len;
      int               made;
      int               burst;
      int               window;
      int               gap;
      bit               gapped;
      int               i;

      req_if.valid = 1'b0;
      req_if.cmd = CMD_INSERT;
      req_if.range_offset = '0;
      req_if.range_length = '0;
      rsp_if.ready = 1'b0;

      // empty report, zero length, widest range, overlap from the left, touch
      add_report(0);
      add_insert(48'd1000, 32'd0, 0);
      add_insert({OFS_W{1'b1}}, {LEN_W{1'b1}}, 0);
      add_insert(48'd0, 32'd10, 0);
      add_insert(48'd5, 32'd15, 3);
      add_insert(48'd20, 32'd10, 0);
      add_report(0);
      // fill the table, then zero length, drop on full, merge while full
      for (i = 0; i < MAX_RANGES; i++)
         add_insert(48'(i * 100), 32'd10, 0);
      add_insert(48'd7000, 32'd0, 0);
      add_insert(48'd5000, 32'd5, 0);
      add_insert(48'd10, 32'd90, 0);
      add_report(0);

      made = 0;
      while (made < RANDOM_ITEMS) begin
         gapped = (made < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 9) == 0) begin
            wide = {$urandom, $urandom};
            gap = pick_gap(gapped);
            if ($urandom_range(0, 1) == 0)
               add_insert(wide[OFS_W-1:0], $urandom, gap);
            else
               add_report(gap);
            made++;
         end else begin
            case ($urandom_range(0, 3))
               0: base = '0;
               1: base = {OFS_W{1'b1}} - $urandom_range(0, 4000);
               default: begin
                  wide = {$urandom, $urandom};
                  base = wide[OFS_W-1:0];
               end
            endcase
            window = ($urandom_range(0, 1) == 0) ? 400 : 3000;
            burst = $urandom_range(1, 30);
            for (i = 0; i < burst; i++) begin
               case ($urandom_range(0, 19))
                  0: len = '0;
                  1: len = $urandom;
                  default: len = $urandom_range(1, 80);
               endcase
               add_insert(base + $urandom_range(0, window), len, pick_gap(gapped));
               made++;
            end
            if ($urandom_range(0, 7) != 0) begin
               add_report(pick_gap(gapped));
               made++;
            end
         end
      end
      add_report(0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() > 0 || req_if.valid)
         @(posedge clock);
      while (due_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
